// File: rtl/xsfb_pkg.sv
package xsfb_pkg;

   localparam int MEM_DEPTH      = 1024;
   localparam int ADDR_W         = 10;
   localparam int WB_W           = 5;
   localparam int H_W            = 7;
   localparam int DIVD_W         = 8;
   localparam int DEF_MAX_WIDTH  = 128;
   localparam int DEF_MAX_HEIGHT = 64;

   localparam logic [7:0] RST_SCREEN_WIDTH  = 8'd64;
   localparam logic [6:0] RST_SCREEN_HEIGHT = 7'd32;

   typedef enum logic [1:0] {
      OP_DRAW  = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2,
      OP_ACK   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_SCREEN_HEIGHT = 2'd1,
      CSR_WRAP_X        = 2'd2,
      CSR_WRAP_Y        = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] x_pos;
      logic [7:0] y_pos;
      logic [3:0] row_index;
      logic [7:0] row_bits;
      logic [9:0] byte_address;
   } req_type;

   typedef struct packed {
      logic       collision;
      logic [7:0] read_data;
      logic       changed;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [H_W-1:0]    divisor;
   } rem_req_type;

   typedef struct packed {
      logic           done;
      logic [H_W-1:0] remainder;
   } rem_rsp_type;

endpackage

// File: rtl/xsfb_rem_unit.sv
module xsfb_rem_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  xsfb_pkg::rem_req_type rem_req,
   output xsfb_pkg::rem_rsp_type rem_rsp
);
   import xsfb_pkg::*;

   localparam int CNT_W = $clog2(DIVD_W);

   logic                active_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [DIVD_W-1:0]   dq_ff;
   logic [H_W-1:0]      d_ff;
   logic [H_W-1:0]      r_ff;
   logic [H_W:0]        trial;
   logic [H_W-1:0]      r_in;

   // restoring remainder, one dividend bit a cycle
   always_comb begin
      trial = {r_ff, dq_ff[DIVD_W-1]};
      if (trial >= {1'b0, d_ff}) begin
         r_in = H_W'(trial - {1'b0, d_ff});
      end else begin
         r_in = trial[H_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (rem_req.start) begin
            active_ff <= 1'b1;
            cnt_ff    <= '0;
            dq_ff     <= rem_req.dividend;
            d_ff      <= rem_req.divisor;
            r_ff      <= '0;
         end else if (active_ff) begin
            r_ff   <= r_in;
            dq_ff  <= {dq_ff[DIVD_W-2:0], 1'b0};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIVD_W - 1)) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
         end
      end
   end

   assign rem_rsp.done      = done_ff;
   assign rem_rsp.remainder = r_ff;

endmodule

// File: rtl/xor_sprite_framebuffer.sv
// xor_sprite_framebuffer: 1 bit per pixel framebuffer, 8 pixels a byte, msb leftmost.
// Request channel: an item is taken at a clock edge with start high and busy low.
//    operation selects draw row, clear, read byte or acknowledge changed flag.
// Response channel: exactly one beat per item, rsp_strobe high for one cycle with
//    collision, read_data and changed on rsp_data. The receiver cannot stall, so a
//    beat is never held back and nothing waits on the response side.
// Config channel: csr_valid/csr_ready (ready always high), csr_index picks
//    width, height, wrap_x or wrap_y. Write only while the block is idle.
// Path from the accepting edge to the response beat: acknowledge answers
//    from S_IDLE, read passes S_MRD and S_MWR, draw passes S_CHECK, S_YCHK,
//    S_LINE, S_MRD and S_MWR (these two again when the row straddles two
//    bytes), with a wait in S_XMOD or S_YMOD on the shared serial remainder
//    unit for each coordinate that wraps by modulo. An abandoned row answers
//    from S_CHECK or S_YCHK, a row below the bottom edge from S_LINE. Clear
//    writes width_bytes * height bytes, one byte a cycle through the single memory write port. Items go one at a time.
// Reset: config returns to 64 x 32 with wrap on, changed flag set. The pixel
//    memory is then zeroed, all 1024 bytes, in S_INIT, during which busy is high.
module xor_sprite_framebuffer #(
   parameter int MAX_WIDTH  = xsfb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = xsfb_pkg::DEF_MAX_HEIGHT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  xsfb_pkg::req_type req_data,
   output logic              rsp_strobe,
   output xsfb_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);
   import xsfb_pkg::*;

   localparam int MaxWb   = MAX_WIDTH / 8;
   localparam int PROD_W  = WB_W + H_W;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_CHECK, S_XMOD, S_YCHK, S_YMOD, S_LINE, S_MRD, S_MWR, S_CLR
   } state_type;

   state_type          state_ff;
   logic [7:0]         width_ff;
   logic [6:0]         height_ff;
   logic               wrap_x_ff;
   logic               wrap_y_ff;
   logic [ADDR_W-1:0]  cnt_ff;
   logic [ADDR_W-1:0]  last_ff;
   logic [1:0]         op_ff;
   logic [7:0]         x_ff;
   logic [WB_W-1:0]    xb_ff;
   logic [7:0]         y_ff;
   logic [3:0]         row_ff;
   logic [7:0]         bits_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic               second_ff;
   logic               coll_ff;
   logic               abort_ff;
   logic               dirty_ff;
   logic               rsp_strobe_ff;
   rsp_type            rsp_ff;
   logic [7:0]         rdata_ff;
   logic [7:0]         mem [MEM_DEPTH];

   logic [WB_W-1:0]    wb;
   logic [H_W-1:0]     h;
   logic [7:0]         w_px;
   logic               x_big;
   logic               y_big;
   logic [8:0]         line;
   logic               line_out;
   logic [PROD_W-1:0]  line_prod;
   logic [ADDR_W-1:0]  pos_first;
   logic [PROD_W-1:0]  clr_prod;
   logic [ADDR_W-1:0]  clr_last;
   logic [15:0]        spr_wide;
   logic [7:0]         spr;
   logic               hit;
   logic               last_col;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_wa;
   logic [7:0]         mem_wd;
   rem_req_type        rem_req;
   rem_rsp_type        rem_rsp;

   // effective screen size
   always_comb begin
      wb = width_ff[7:3];
      if (int'(width_ff[7:3]) > MaxWb) begin
         wb = WB_W'(MaxWb);
      end
      if (wb == '0) begin
         wb = WB_W'(1);
      end
      h = height_ff;
      if (int'(height_ff) > MAX_HEIGHT) begin
         h = H_W'(MAX_HEIGHT);
      end
      if (h == '0) begin
         h = H_W'(1);
      end
   end

   assign w_px      = {wb, 3'b000};
   assign x_big     = x_ff >= w_px;
   assign y_big     = y_ff >= {1'b0, h};
   assign line      = {1'b0, y_ff} + {5'b0, row_ff};
   assign line_out  = line >= {2'b00, h};
   assign line_prod = wb * line[H_W-1:0];
   assign pos_first = ADDR_W'(line_prod + PROD_W'(xb_ff));
   assign clr_prod  = wb * h;
   assign clr_last  = (clr_prod > PROD_W'(MEM_DEPTH)) ? '1 : ADDR_W'(clr_prod - 1'b1);
   assign spr_wide  = {bits_ff, 8'h00} >> x_ff[2:0];
   assign spr       = second_ff ? spr_wide[7:0] : spr_wide[15:8];
   assign hit       = |(rdata_ff & spr);
   assign last_col  = xb_ff == WB_W'(wb - 1'b1);

   always_comb begin
      rem_req.start    = 1'b0;
      rem_req.dividend = y_ff;
      rem_req.divisor  = h;
      if (state_ff == S_CHECK) begin
         rem_req.start    = !abort_ff && x_big && wrap_x_ff;
         rem_req.dividend = {3'b000, xb_ff};
         rem_req.divisor  = {2'b00, wb};
      end else if (state_ff == S_YCHK) begin
         rem_req.start = y_big && wrap_y_ff;
      end
   end

   xsfb_rem_unit u_rem (
      .clock   (clock),
      .reset   (reset),
      .rem_req (rem_req),
      .rem_rsp (rem_rsp)
   );

   // memory write port: zeroing sweeps or the xor write-back
   always_comb begin
      mem_we = 1'b0;
      mem_wa = addr_ff;
      mem_wd = rdata_ff ^ spr;
      if (state_ff == S_INIT || state_ff == S_CLR) begin
         mem_we = 1'b1;
         mem_wa = cnt_ff;
         mem_wd = 8'h00;
      end else if (state_ff == S_MWR && op_ff == OP_DRAW) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= mem[addr_ff];
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_SCREEN_WIDTH;
         height_ff <= RST_SCREEN_HEIGHT;
         wrap_x_ff <= 1'b1;
         wrap_y_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata;
            CSR_SCREEN_HEIGHT: height_ff <= csr_wdata[6:0];
            CSR_WRAP_X:        wrap_x_ff <= csr_wdata[0];
            CSR_WRAP_Y:        wrap_y_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         cnt_ff        <= '0;
         last_ff       <= '1;
         coll_ff       <= 1'b0;
         abort_ff      <= 1'b0;
         dirty_ff      <= 1'b1;
         rsp_strobe_ff <= 1'b0;
         op_ff         <= OP_DRAW;
         second_ff     <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            S_INIT, S_CLR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == last_ff) begin
                  state_ff <= S_IDLE;
                  if (state_ff == S_CLR) begin
                     rsp_strobe_ff <= 1'b1;
                     rsp_ff        <= '{collision: coll_ff, read_data: 8'h00, changed: 1'b1};
                  end
               end
            end
            S_IDLE: begin
               if (start) begin
                  op_ff     <= req_data.operation;
                  x_ff      <= req_data.x_pos;
                  xb_ff     <= req_data.x_pos[7:3];
                  y_ff      <= req_data.y_pos;
                  row_ff    <= req_data.row_index;
                  bits_ff   <= req_data.row_bits;
                  addr_ff   <= req_data.byte_address;
                  second_ff <= 1'b0;
                  case (req_data.operation)
                     OP_DRAW: begin
                        if (req_data.row_index == 4'd0) begin
                           coll_ff  <= 1'b0;
                           abort_ff <= 1'b0;
                        end
                        state_ff <= S_CHECK;
                     end
                     OP_CLEAR: begin
                        cnt_ff   <= '0;
                        last_ff  <= clr_last;
                        dirty_ff <= 1'b1;
                        state_ff <= S_CLR;
                     end
                     OP_READ: begin
                        state_ff <= S_MRD;
                     end
                     default: begin
                        dirty_ff      <= 1'b0;
                        rsp_strobe_ff <= 1'b1;
                        rsp_ff        <= '{collision: coll_ff, read_data: 8'h00,
                                           changed: dirty_ff};
                     end
                  endcase
               end
            end
            S_CHECK: begin
               if (abort_ff || (x_big && !wrap_x_ff)) begin
                  abort_ff      <= 1'b1;
                  state_ff      <= S_IDLE;
                  rsp_strobe_ff <= 1'b1;
                  rsp_ff        <= '{collision: coll_ff, read_data: 8'h00, changed: dirty_ff};
               end else if (x_big) begin
                  state_ff <= S_XMOD;
               end else begin
                  state_ff <= S_YCHK;
               end
            end
            S_XMOD: begin
               if (rem_rsp.done) begin
                  xb_ff    <= rem_rsp.remainder[WB_W-1:0];
                  state_ff <= S_YCHK;
               end
            end
            S_YCHK: begin
               if (y_big && !wrap_y_ff) begin
                  abort_ff      <= 1'b1;
                  state_ff      <= S_IDLE;
                  rsp_strobe_ff <= 1'b1;
                  rsp_ff        <= '{collision: coll_ff, read_data: 8'h00, changed: dirty_ff};
               end else if (y_big) begin
                  state_ff <= S_YMOD;
               end else begin
                  state_ff <= S_LINE;
               end
            end
            S_YMOD: begin
               if (rem_rsp.done) begin
                  y_ff     <= {1'b0, rem_rsp.remainder};
                  state_ff <= S_LINE;
               end
            end
            S_LINE: begin
               dirty_ff <= 1'b1;
               if (line_out) begin
                  // below the bottom edge: nothing drawn, flag still set
                  state_ff      <= S_IDLE;
                  rsp_strobe_ff <= 1'b1;
                  rsp_ff        <= '{collision: coll_ff, read_data: 8'h00, changed: 1'b1};
               end else begin
                  addr_ff  <= pos_first;
                  state_ff <= S_MRD;
               end
            end
            S_MRD: begin
               state_ff <= S_MWR;
            end
            S_MWR: begin
               if (op_ff == OP_READ) begin
                  state_ff      <= S_IDLE;
                  rsp_strobe_ff <= 1'b1;
                  rsp_ff        <= '{collision: coll_ff, read_data: rdata_ff,
                                     changed: dirty_ff};
               end else begin
                  coll_ff <= coll_ff | hit;
                  if (!second_ff && x_ff[2:0] != 3'd0 && (!last_col || wrap_x_ff)) begin
                     // straddling row: second byte, wrapped to line start at the edge
                     second_ff <= 1'b1;
                     addr_ff   <= last_col ? addr_ff + 1'b1 - ADDR_W'(wb) : addr_ff + 1'b1;
                     state_ff  <= S_MRD;
                  end else begin
                     state_ff      <= S_IDLE;
                     rsp_strobe_ff <= 1'b1;
                     rsp_ff        <= '{collision: coll_ff | hit, read_data: 8'h00,
                                        changed: dirty_ff};
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;
   assign csr_ready  = 1'b1;

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_strobe)
      else $error("accepted item neither in progress nor answered");

   a_read_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && op_ff != OP_READ |-> rsp_ff.read_data == 8'h00)
      else $error("read data on a non-read response");

   a_rem_done_state: assert property (@(posedge clock) disable iff (reset)
      rem_rsp.done |-> state_ff == S_XMOD || state_ff == S_YMOD)
      else $error("remainder finished outside a modulo wait");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff != S_IDLE)
      else $error("memory written while idle");

endmodule

// File: dv/xor_sprite_framebuffer_test.sv
`timescale 1ns / 100ps

module xor_sprite_framebuffer_test;
   import xsfb_pkg::*;

   localparam int CYCLE_LIMIT  = 5_000_000;
   localparam int PHASE_ITEMS  = 130;
   localparam int WIDTH_BYTES_MAX = DEF_MAX_WIDTH / 8;

   typedef struct packed {
      logic          is_csr;
      csr_index_type reg_sel;
      logic [7:0]    reg_val;
      req_type       item;
      logic          typed;
      rsp_type       want;
   } plan_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = 2'd0;
   logic [7:0] csr_wdata = 8'd0;

   // shadow of the framebuffer and its flags
   logic [7:0] fb_shadow [0:MEM_DEPTH-1];
   logic       sprite_hit;
   logic       sprite_dead;
   logic       dirty_shadow;
   logic [7:0] cfg_width;
   logic [6:0] cfg_height;
   logic       cfg_wrap_x;
   logic       cfg_wrap_y;

   rsp_type    pending_rsp [$];
   int         error_count = 0;
   int         cycle_count = 0;
   logic       no_idle = 1'b0;

   xor_sprite_framebuffer DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned width_bytes();
      int unsigned b;
      b = cfg_width >> 3;
      if (b > WIDTH_BYTES_MAX) b = WIDTH_BYTES_MAX;
      if (b == 0) b = 1;
      return b;
   endfunction

   function automatic int unsigned height_lines();
      int unsigned h;
      h = cfg_height;
      if (h > DEF_MAX_HEIGHT) h = DEF_MAX_HEIGHT;
      if (h == 0) h = 1;
      return h;
   endfunction

   function automatic void xor_into(int unsigned pos, logic [7:0] spr);
      pos = pos % MEM_DEPTH;
      if ((fb_shadow[pos] & spr) != 8'h00) sprite_hit = 1'b1;
      fb_shadow[pos] = fb_shadow[pos] ^ spr;
   endfunction

   function automatic void xor_draw_row(req_type rq);
      int unsigned wb, w, h, x, y, line, sh, pos;
      logic [15:0] spread;
      wb = width_bytes();
      w  = wb * 8;
      h  = height_lines();
      x  = rq.x_pos;
      y  = rq.y_pos;
      if (rq.row_index == 4'd0) begin
         sprite_hit  = 1'b0;
         sprite_dead = 1'b0;
      end
      if (sprite_dead) return;
      if (x >= w) begin
         if (!cfg_wrap_x) begin
            sprite_dead = 1'b1;
            return;
         end
         x = x % w;
      end
      if (y >= h) begin
         if (!cfg_wrap_y) begin
            sprite_dead = 1'b1;
            return;
         end
         y = y % h;
      end
      dirty_shadow = 1'b1;
      line = y + rq.row_index;
      if (line >= h) return;
      sh     = x & 7;
      spread = {rq.row_bits, 8'h00} >> sh;
      pos    = wb * line + (x >> 3);
      xor_into(pos, spread[15:8]);
      if (sh != 0) begin
         pos = pos + 1;
         // second byte runs off the right edge
         if (x + 8 >= w) begin
            if (!cfg_wrap_x) return;
            pos = pos - wb;
         end
         xor_into(pos, spread[7:0]);
      end
   endfunction

   function automatic rsp_type predict_response(req_type rq);
      rsp_type got;
      int unsigned n;
      got = '0;
      case (op_type'(rq.operation))
         OP_DRAW: begin
            xor_draw_row(rq);
            got.changed = dirty_shadow;
         end
         OP_CLEAR: begin
            n = width_bytes() * height_lines();
            for (int i = 0; i < n; i++) fb_shadow[i] = 8'h00;
            dirty_shadow = 1'b1;
            got.changed  = dirty_shadow;
         end
         OP_READ: begin
            got.read_data = fb_shadow[rq.byte_address];
            got.changed   = dirty_shadow;
         end
         default: begin
            got.changed  = dirty_shadow;
            dirty_shadow = 1'b0;
         end
      endcase
      got.collision = sprite_hit;
      return got;
   endfunction

   function automatic req_type random_req();
      req_type rq;
      rq.operation    = 2'($urandom_range(3));
      rq.x_pos        = 8'($urandom_range(255));
      rq.y_pos        = 8'($urandom_range(255));
      rq.row_index    = 4'($urandom_range(15));
      rq.row_bits     = 8'($urandom_range(255));
      rq.byte_address = 10'($urandom_range(1023));
      return rq;
   endfunction

   function automatic plan_row_type item_row(op_type op, logic [7:0] x, logic [7:0] y,
                                             logic [3:0] row, logic [7:0] bits,
                                             logic [9:0] addr, logic typed, rsp_type want);
      plan_row_type pr;
      pr = '0;
      pr.item.operation    = op;
      pr.item.x_pos        = x;
      pr.item.y_pos        = y;
      pr.item.row_index    = row;
      pr.item.row_bits     = bits;
      pr.item.byte_address = addr;
      pr.typed = typed;
      pr.want  = want;
      return pr;
   endfunction

   function automatic plan_row_type csr_row(csr_index_type sel, logic [7:0] val);
      plan_row_type pr;
      pr = '0;
      pr.is_csr  = 1'b1;
      pr.reg_sel = sel;
      pr.reg_val = val;
      return pr;
   endfunction

   // response checker: the receiver never stalls, every strobe is a beat
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: response beat with none pending, got %h", $time, rsp_data);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.collision !== want.collision) begin
               $display("%0t: collision expected %0b got %0b", $time,
                        want.collision, rsp_data.collision);
               error_count++;
            end
            if (rsp_data.read_data !== want.read_data) begin
               $display("%0t: read_data expected %h got %h", $time,
                        want.read_data, rsp_data.read_data);
               error_count++;
            end
            if (rsp_data.changed !== want.changed) begin
               $display("%0t: changed expected %0b got %0b", $time,
                        want.changed, rsp_data.changed);
               error_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   task automatic send_item(req_type rq, logic typed, rsp_type want);
      rsp_type got;
      if (!no_idle) begin
         while ($urandom_range(99) < 17) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start    <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy !== 1'b0);
      got = predict_response(rq);
      pending_rsp.push_back(typed ? want : got);
   endtask

   // block is idle once every beat is back and busy has dropped
   task automatic drain_pending();
      start <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0 || busy !== 1'b0);
   endtask

   task automatic write_csr(csr_index_type sel, logic [7:0] val);
      if (!no_idle) begin
         while ($urandom_range(99) < 17) begin
            csr_valid <= 1'b0;
            @(posedge clock);
         end
      end
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (sel)
         CSR_SCREEN_WIDTH:  cfg_width  = val;
         CSR_SCREEN_HEIGHT: cfg_height = val[6:0];
         CSR_WRAP_X:        cfg_wrap_x = val[0];
         default:           cfg_wrap_y = val[0];
      endcase
   endtask

   task automatic set_screen(logic [7:0] w, logic [6:0] h, logic wx, logic wy);
      drain_pending();
      write_csr(CSR_SCREEN_WIDTH, w);
      write_csr(CSR_SCREEN_HEIGHT, {1'b0, h});
      write_csr(CSR_WRAP_X, {7'd0, wx});
      write_csr(CSR_WRAP_Y, {7'd0, wy});
      csr_valid <= 1'b0;
   endtask

   initial begin
      plan_row_type plan [$];
      req_type      rq;
      logic [7:0]   sprite_x, sprite_y;
      logic [7:0]   sprite_bits [0:15];
      int           sprite_len;
      logic         have_sprite;
      int           done_items;
      int           pick;

      for (int i = 0; i < MEM_DEPTH; i++) fb_shadow[i] = 8'h00;
      sprite_hit   = 1'b0;
      sprite_dead  = 1'b0;
      dirty_shadow = 1'b1;
      cfg_width    = RST_SCREEN_WIDTH;
      cfg_height   = RST_SCREEN_HEIGHT;
      cfg_wrap_x   = 1'b1;
      cfg_wrap_y   = 1'b1;

      // directed part, 64 x 32 with wrap on until the wrap registers are cleared
      plan.push_back(item_row(OP_ACK,   0,   0,   0,  8'h00, 0,    1, {1'b0, 8'h00, 1'b1}));
      plan.push_back(item_row(OP_ACK,   0,   0,   0,  8'h00, 0,    1, {1'b0, 8'h00, 1'b0}));
      plan.push_back(item_row(OP_READ,  0,   0,   0,  8'h00, 1023, 1, {1'b0, 8'h00, 1'b0}));
      plan.push_back(item_row(OP_DRAW,  0,   0,   0,  8'hFF, 0,    1, {1'b0, 8'h00, 1'b1}));
      plan.push_back(item_row(OP_READ,  0,   0,   0,  8'h00, 0,    1, {1'b0, 8'hFF, 1'b1}));
      plan.push_back(item_row(OP_DRAW,  0,   0,   0,  8'h81, 0,    1, {1'b1, 8'h00, 1'b1}));
      plan.push_back(item_row(OP_DRAW,  0,   0,   1,  8'h00, 0,    1, {1'b1, 8'h00, 1'b1}));
      // straddle onto the line start
      plan.push_back(item_row(OP_DRAW,  61,  0,   0,  8'hFF, 0,    0, '0));
      plan.push_back(item_row(OP_READ,  0,   0,   0,  8'h00, 0,    0, '0));
      plan.push_back(item_row(OP_READ,  0,   0,   0,  8'h00, 7,    0, '0));
      plan.push_back(item_row(OP_DRAW,  200, 40,  0,  8'hA5, 0,    0, '0));
      // wraps both ways, then falls below the bottom edge
      plan.push_back(item_row(OP_DRAW,  255, 255, 15, 8'hFF, 1023, 0, '0));
      plan.push_back(item_row(OP_CLEAR, 0,   0,   0,  8'h00, 0,    0, '0));
      plan.push_back(item_row(OP_READ,  0,   0,   0,  8'h00, 7,    0, '0));
      plan.push_back(csr_row(CSR_WRAP_X, 8'd0));
      plan.push_back(csr_row(CSR_WRAP_Y, 8'd0));
      plan.push_back(item_row(OP_DRAW,  60,  2,   0,  8'hFF, 0,    0, '0));
      plan.push_back(item_row(OP_READ,  0,   0,   0,  8'h00, 23,   0, '0));
      plan.push_back(item_row(OP_READ,  0,   0,   0,  8'h00, 16,   0, '0));
      plan.push_back(item_row(OP_DRAW,  64,  2,   0,  8'hFF, 0,    0, '0));
      plan.push_back(item_row(OP_DRAW,  0,   2,   1,  8'hFF, 0,    0, '0));
      plan.push_back(item_row(OP_DRAW,  0,   32,  0,  8'hFF, 0,    0, '0));
      plan.push_back(item_row(OP_READ,  0,   0,   0,  8'h00, 24,   0, '0));
      plan.push_back(csr_row(CSR_SCREEN_WIDTH, 8'd255));
      plan.push_back(csr_row(CSR_SCREEN_HEIGHT, 8'd0));
      plan.push_back(item_row(OP_DRAW,  124, 0,   0,  8'h3C, 0,    0, '0));
      plan.push_back(item_row(OP_READ,  0,   0,   0,  8'h00, 15,   0, '0));
      plan.push_back(item_row(OP_CLEAR, 0,   0,   0,  8'h00, 0,    0, '0));
      plan.push_back(item_row(OP_READ,  0,   0,   0,  8'h00, 15,   0, '0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            drain_pending();
            write_csr(plan[i].reg_sel, plan[i].reg_val);
            csr_valid <= 1'b0;
         end else begin
            send_item(plan[i].item, plan[i].typed, plan[i].want);
         end
      end

      have_sprite = 1'b0;
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: set_screen(8'd64, 7'd32, 1'b1, 1'b1);
            1: set_screen(8'd128, 7'd64, 1'b0, 1'b0);
            2: set_screen(8'd8, 7'd1, 1'b1, 1'b1);
            3: set_screen(8'd0, 7'd0, 1'b0, 1'b1);
            4: set_screen(8'd255, 7'd127, 1'b1, 1'b0);
            default: set_screen(8'($urandom_range(255)), 7'($urandom_range(127)),
                                1'($urandom_range(1)), 1'($urandom_range(1)));
         endcase
         // phase 2 runs back to back, with no random idle gaps
         no_idle    = (phase == 2);
         done_items = 0;
         while (done_items < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            rq   = random_req();
            if (pick < 55) begin
               // a sprite: fresh, or the last one again to erase it
               if (!(have_sprite && pick >= 40)) begin
                  sprite_x = ($urandom_range(9) < 7)
                             ? 8'($urandom_range(width_bytes() * 8 - 1))
                             : 8'($urandom_range(255));
                  sprite_y = ($urandom_range(9) < 7)
                             ? 8'($urandom_range(height_lines() - 1))
                             : 8'($urandom_range(255));
                  sprite_len = ($urandom_range(9) < 8) ? $urandom_range(8, 1)
                                                      : $urandom_range(16, 9);
                  for (int r = 0; r < 16; r++) sprite_bits[r] = 8'($urandom_range(255));
                  have_sprite = 1'b1;
               end
               for (int r = 0; r < sprite_len; r++) begin
                  rq = random_req();
                  rq.operation = OP_DRAW;
                  rq.x_pos     = sprite_x;
                  rq.y_pos     = sprite_y;
                  rq.row_index = 4'(r);
                  rq.row_bits  = sprite_bits[r];
                  send_item(rq, 1'b0, '0);
               end
               done_items += sprite_len;
            end else begin
               if (pick < 63) begin
                  rq.operation = OP_DRAW;
               end else if (pick < 85) begin
                  rq.operation = OP_READ;
                  if ($urandom_range(9) < 7)
                     rq.byte_address =
                        10'($urandom_range(width_bytes() * height_lines() - 1));
               end else if (pick < 95) begin
                  rq.operation = OP_ACK;
               end else if (pick < 98) begin
                  rq.operation = OP_CLEAR;
               end else begin
                  rq.operation = OP_READ;
               end
               send_item(rq, 1'b0, '0);
               done_items++;
            end
         end
      end

      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/xsfb_pkg.sv
rtl/xsfb_rem_unit.sv
rtl/xor_sprite_framebuffer.sv
dv/xor_sprite_framebuffer_test.sv
